### hw/rtl/stp_pkg.sv
// Shared types, constants and helper functions for the transmission profile unit.
package stp_pkg;

  localparam int STP_MAX_PROFILE_SIZE = 256;

  localparam int NUM_W = 55;
  localparam int DEN_W = 48;
  localparam int Q_W   = 26;
  localparam int X_W   = 25;
  localparam int E_W   = 33;

  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int POST_LAT  = 1;
  localparam int EXP_LAT   = 18;
  localparam int MIX_LAT   = 2;
  localparam int LINE_LEN  = FRONT_LAT + DIV_LAT + POST_LAT + EXP_LAT + MIX_LAT;

  localparam logic [15:0]    ALBEDO_OFFSET = 16'd21627;
  localparam logic [21:0]    S_BASE        = 22'd229376;
  localparam logic [30:0]    LOG2E_Q30     = 31'd1549082005;
  localparam logic [X_W-1:0] X_CLAMP       = X_W'(25'h100_0000);
  localparam logic [15:0]    ONE_Q15       = 16'd32768;
  localparam logic [25:0]    DIV3_MULT     = 26'd44739243;

  typedef enum logic [2:0] {
    REG_PROFILE_SIZE = 3'd0,
    REG_ALBEDO       = 3'd1,
    REG_MEAN_FREE    = 3'd2,
    REG_TINT         = 3'd3,
    REG_UNIT_SCALE   = 3'd4,
    REG_EXTINCTION   = 3'd5
  } stp_reg_t;

  typedef struct packed {
    logic [8:0]  profile_size;
    logic [47:0] albedo_rgb;
    logic [47:0] mean_free_path_rgb;
    logic [47:0] tint_rgb;
    logic [15:0] unit_scale;
    logic [15:0] extinction_scale;
  } stp_cfg_t;

  function automatic logic [15:0] chan16(input logic [47:0] v, input int ch);
    return v[16*(2-ch) +: 16];
  endfunction

  function automatic logic [8:0] clamp_size(input logic [8:0] ps, input int max_size);
    logic [12:0] m;
    m = 13'(max_size);
    if (ps == 9'd0) return 9'd1;
    else if ({4'd0, ps} > m) return m[8:0];
    else return ps;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res = '0;
    rem = v;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > v) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] exp_coef(input int j);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 1; i < j; i++) begin
      c = isqrt64({c[31:0], 32'd0});
    end
    return c[31:0];
  endfunction

endpackage

### hw/rtl/stp_front.sv
// Front pipeline: scaling factors, dividends and divisors for every channel and the shadow.
module stp_front import stp_pkg::*; #(
  parameter int MAX_PROFILE_SIZE = STP_MAX_PROFILE_SIZE
) (
  input  logic                        clk,
  input  logic                        en,
  input  stp_cfg_t                    cfg,
  input  logic [7:0]                  sample_index,
  output logic [2:0][NUM_W-1:0]       num,
  output logic [2:0][DEN_W-1:0]       den,
  output logic [NUM_W-1:0]            snum,
  output logic [DEN_W-1:0]            sden
);

  logic [8:0]        n1_r;
  logic [15:0]       u1_r;
  logic [7:0]        idx1_r;
  logic [2:0][15:0]  diff_nxt;
  logic [2:0][15:0]  diff1_r;

  logic [2:0][31:0]  d2_r;
  logic [16:0]       rnum2_r;
  logic [24:0]       nu2_r;
  logic [26:0]       se2_r;

  logic [2:0][63:0]  sq;
  logic [2:0][29:0]  d4_r;
  logic [2:0][40:0]  denl3_r;
  logic [16:0]       rnum3_r;
  logic [42:0]       snum3_r;
  logic [24:0]       sden3_r;

  logic [2:0][36:0]  s_sum;
  logic [2:0][21:0]  s4_r;
  logic [2:0][47:0]  den4_r;
  logic [16:0]       rnum4_r;
  logic [42:0]       snum4_r;
  logic [24:0]       sden4_r;

  logic [2:0][NUM_W-1:0] num5_r;
  logic [2:0][DEN_W-1:0] den5_r;
  logic [NUM_W-1:0]      snum5_r;
  logic [DEN_W-1:0]      sden5_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (chan16(cfg.albedo_rgb, ch) >= ALBEDO_OFFSET) begin
        diff_nxt[ch] = chan16(cfg.albedo_rgb, ch) - ALBEDO_OFFSET;
      end else begin
        diff_nxt[ch] = ALBEDO_OFFSET - chan16(cfg.albedo_rgb, ch);
      end
      sq[ch] = 64'(d2_r[ch]) * 64'(d2_r[ch]);
      s_sum[ch] = ((37'(d4_r[ch]) * 37'd100) + 37'd32768) >> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r    <= clamp_size(cfg.profile_size, MAX_PROFILE_SIZE);
      u1_r    <= (cfg.unit_scale == 16'd0) ? 16'd1 : cfg.unit_scale;
      idx1_r  <= sample_index;
      diff1_r <= diff_nxt;

      for (int ch = 0; ch < 3; ch++) begin
        d2_r[ch]    <= 32'(diff1_r[ch]) * 32'(diff1_r[ch]);
        d4_r[ch]    <= sq[ch][61:32];
        denl3_r[ch] <= 41'(nu2_r) * 41'(chan16(cfg.mean_free_path_rgb, ch));
        s4_r[ch]    <= S_BASE + s_sum[ch][21:0];
        den4_r[ch]  <= 48'(denl3_r[ch]) * 48'd100;
        num5_r[ch]  <= {39'(39'(s4_r[ch]) * 39'(rnum4_r)), 16'd0};
        den5_r[ch]  <= den4_r[ch];
      end

      rnum2_r <= (17'(idx1_r) * 17'd500) + (17'(n1_r) * 17'd6);
      nu2_r   <= 25'(n1_r) * 25'(u1_r);
      se2_r   <= 27'(idx1_r) * 27'd5 * 27'(cfg.extinction_scale);

      rnum3_r <= rnum2_r;
      snum3_r <= {se2_r, 16'd0};
      sden3_r <= nu2_r;

      rnum4_r <= rnum3_r;
      snum4_r <= snum3_r;
      sden4_r <= sden3_r;

      snum5_r <= NUM_W'(snum4_r);
      sden5_r <= DEN_W'(sden4_r);
    end
  end

  assign num  = num5_r;
  assign den  = den5_r;
  assign snum = snum5_r;
  assign sden = sden5_r;

endmodule

### hw/rtl/stp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module stp_div import stp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   q
);

  localparam int WIDE = DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W-1];
  logic             sat_r [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= WIDE'(num) >= (WIDE'(den) << Q_W);
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [WIDE-1:0] dsh;
    logic            take;

    assign dsh  = WIDE'(den_r[k]) << (Q_W - 1 - k);
    assign take = WIDE'(rem_r[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? NUM_W'(WIDE'(rem_r[k]) - dsh) : rem_r[k];
        sat_r[k+1] <= sat_r[k];
        q_r[k+1]   <= {q_r[k][Q_W-2:0], take};
      end
    end

    if (k < Q_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign q = sat_r[Q_W] ? '1 : q_r[Q_W];

endmodule

### hw/rtl/stp_exp.sv
// Pipelined exp(-x): base-two split, one fractional bit per stage, final shift.
module stp_exp import stp_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [X_W-1:0] x,
  output logic [E_W-1:0] e
);

  localparam logic [E_W-1:0] ONE_Q32 = E_W'(33'h1_0000_0000);

  logic [57:0]    y_full;
  logic [9:0]     k_r [0:16];
  logic [15:0]    f_r [0:15];
  logic [E_W-1:0] acc_r [1:16];
  logic [E_W-1:0] acc_in [1:16];
  logic [E_W-1:0] e_r;

  assign y_full = (58'(x) * 58'(LOG2E_Q30)) + 58'(30'h2000_0000);

  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0] <= y_full[55:46];
      f_r[0] <= y_full[45:30];
    end
  end

  for (genvar j = 1; j <= 16; j++) begin : g_step
    localparam logic [31:0] C = exp_coef(j);
    logic [65:0] prod;

    if (j == 1) begin : g_first
      assign acc_in[j] = ONE_Q32;
    end else begin : g_next
      assign acc_in[j] = acc_r[j-1];
    end

    assign prod = 66'(acc_in[j]) * 66'(C);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j] <= f_r[j-1][16-j] ? E_W'(prod >> 32) : acc_in[j];
        k_r[j]   <= k_r[j-1];
      end
    end

    if (j < 16) begin : g_frac
      always_ff @(posedge clk) begin
        if (en) begin
          f_r[j] <= f_r[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= (k_r[16] >= 10'd32) ? '0 : (acc_r[16] >> k_r[16][4:0]);
    end
  end

  assign e = e_r;

endmodule

### hw/rtl/sss_transmission_profile_unit.sv
// Top level of the subsurface transmission profile texel generator.
//
// Usage: program the six registers through the cfg_ channel (index, data;
// cfg_ready is always high) while no transaction is in flight. Then send
// profile entry indexes on the in_ channel; each accepted transaction yields
// exactly one result transaction on the out_ channel carrying red, green,
// blue and shadow in Q1.15, in the order the indexes were accepted.
// Throughput: one transaction per cycle unless the output stalls, set by
// the fully pipelined divider (one quotient bit per stage) and the
// exponential pipeline (one fractional bit per stage).
// Reset: synchronous active-low reset empties the pipeline and loads the
// register defaults (32 entries, albedo 0, mean free path 1.0, full tint,
// unit scale 1.0, extinction 1.0).
// Stall: while a result is held with out_ready low, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated, and the pipeline
// keeps filling bubbles until the output register is occupied.
module sss_transmission_profile_unit import stp_pkg::*; #(
  parameter int MAX_PROFILE_SIZE = STP_MAX_PROFILE_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_shadow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  stp_cfg_t cfg_r;

  logic en;
  logic v_r    [0:LINE_LEN-1];
  logic last_r [0:LINE_LEN-1];
  logic [8:0] n_cur;
  logic last_nxt;

  logic [2:0][NUM_W-1:0] num;
  logic [2:0][DEN_W-1:0] den;
  logic [NUM_W-1:0]      snum;
  logic [DEN_W-1:0]      sden;

  logic [2:0][Q_W-1:0]   qc;
  logic [Q_W-1:0]        qs;
  logic [2:0][X_W-1:0]   x1_r;
  logic [2:0][X_W-1:0]   x3_r;
  logic [X_W-1:0]        xs_r;
  logic [2:0][51:0]      x3_prod;
  logic [2:0][X_W-1:0]   x3_q;
  logic [2:0][E_W-1:0]   e1;
  logic [2:0][E_W-1:0]   e3;
  logic [E_W-1:0]        es;
  logic [2:0][34:0]      sum;
  logic [2:0][50:0]      t1_full;
  logic [2:0][34:0]      t1_r;
  logic [2:0][50:0]      p_r;
  logic [2:0][51:0]      p_rnd;
  logic [2:0][15:0]      col;
  logic [E_W-1:0]        es1_r;
  logic [E_W-1:0]        es2_r;
  logic [E_W:0]          es_rnd;
  logic [15:0]           shadow_val;

  logic        out_valid_r;
  logic [15:0] out_red_r;
  logic [15:0] out_green_r;
  logic [15:0] out_blue_r;
  logic [15:0] out_shadow_r;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.profile_size       <= 9'd32;
      cfg_r.albedo_rgb         <= '0;
      cfg_r.mean_free_path_rgb <= 48'h0100_0100_0100;
      cfg_r.tint_rgb           <= '1;
      cfg_r.unit_scale         <= 16'd256;
      cfg_r.extinction_scale   <= 16'd256;
    end else if (cfg_valid) begin
      case (stp_reg_t'(cfg_index))
        REG_PROFILE_SIZE: cfg_r.profile_size       <= cfg_data[8:0];
        REG_ALBEDO:       cfg_r.albedo_rgb         <= cfg_data;
        REG_MEAN_FREE:    cfg_r.mean_free_path_rgb <= cfg_data;
        REG_TINT:         cfg_r.tint_rgb           <= cfg_data;
        REG_UNIT_SCALE:   cfg_r.unit_scale         <= cfg_data[15:0];
        REG_EXTINCTION:   cfg_r.extinction_scale   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign n_cur    = clamp_size(cfg_r.profile_size, MAX_PROFILE_SIZE);
  assign last_nxt = {1'b0, in_sample_index} >= (n_cur - 9'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_LEN; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < LINE_LEN; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= last_nxt;
      for (int i = 1; i < LINE_LEN; i++) last_r[i] <= last_r[i-1];
    end
  end

  stp_front #(.MAX_PROFILE_SIZE(MAX_PROFILE_SIZE)) u_front (
    .clk          (clk),
    .en           (en),
    .cfg          (cfg_r),
    .sample_index (in_sample_index),
    .num          (num),
    .den          (den),
    .snum         (snum),
    .sden         (sden)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    stp_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[ch]),
      .den (den[ch]),
      .q   (qc[ch])
    );

    assign x3_prod[ch] = 52'(qc[ch]) * 52'(DIV3_MULT);
    assign x3_q[ch]    = x3_prod[ch][51:27];

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r[ch] <= (qc[ch] >= Q_W'(X_CLAMP)) ? X_CLAMP : qc[ch][X_W-1:0];
        x3_r[ch] <= (x3_q[ch] >= X_CLAMP) ? X_CLAMP : x3_q[ch];
      end
    end

    stp_exp u_exp1 (
      .clk (clk),
      .en  (en),
      .x   (x1_r[ch]),
      .e   (e1[ch])
    );

    stp_exp u_exp3 (
      .clk (clk),
      .en  (en),
      .x   (x3_r[ch]),
      .e   (e3[ch])
    );

    assign sum[ch]     = 35'(e1[ch]) + (35'(e3[ch]) * 35'd3);
    assign t1_full[ch] = 51'(sum[ch]) * 51'(chan16(cfg_r.albedo_rgb, ch));
    assign p_rnd[ch]   = 52'(p_r[ch]) + 52'h4_0000_0000;
    assign col[ch]     = (p_rnd[ch][51:35] > 17'(ONE_Q15)) ? ONE_Q15 : p_rnd[ch][50:35];

    always_ff @(posedge clk) begin
      if (en) begin
        t1_r[ch] <= t1_full[ch][50:16];
        p_r[ch]  <= 51'(t1_r[ch]) * 51'(chan16(cfg_r.tint_rgb, ch));
      end
    end
  end

  stp_div u_div_shadow (
    .clk (clk),
    .en  (en),
    .num (snum),
    .den (sden),
    .q   (qs)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r  <= (qs >= Q_W'(X_CLAMP)) ? X_CLAMP : qs[X_W-1:0];
      es1_r <= es;
      es2_r <= es1_r;
    end
  end

  stp_exp u_exp_shadow (
    .clk (clk),
    .en  (en),
    .x   (xs_r),
    .e   (es)
  );

  assign es_rnd     = (E_W+1)'(es2_r) + (E_W+1)'(17'h1_0000);
  assign shadow_val = (es_rnd[E_W:17] > (E_W-16)'(ONE_Q15)) ? ONE_Q15 : es_rnd[32:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[LINE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last_r[LINE_LEN-1]) begin
        out_red_r    <= '0;
        out_green_r  <= '0;
        out_blue_r   <= '0;
        out_shadow_r <= ONE_Q15;
      end else begin
        out_red_r    <= (chan16(cfg_r.mean_free_path_rgb, 0) == 16'd0) ? 16'd0 : col[0];
        out_green_r  <= (chan16(cfg_r.mean_free_path_rgb, 1) == 16'd0) ? 16'd0 : col[1];
        out_blue_r   <= (chan16(cfg_r.mean_free_path_rgb, 2) == 16'd0) ? 16'd0 : col[2];
        out_shadow_r <= shadow_val;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_red_r;
  assign out_green  = out_green_r;
  assign out_blue   = out_blue_r;
  assign out_shadow = out_shadow_r;

endmodule
